// ===== hdl/ckc_pkg.sv =====
`timescale 1ns / 1ps

package ckc_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned SumW   = PixW + 2;
  localparam int unsigned DomW   = 16;
  localparam int unsigned ShadW  = 12;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned ShProdW = PixW + ShadW;
  localparam int unsigned DomProdW = DomW + SumW;
  localparam int unsigned BlendW = 2 * PixW;

  localparam logic [PixW-1:0] PixMax = 8'd255;

  typedef enum logic [IdxW-1:0] {
    REG_KEY_BLUE     = 3'd0,
    REG_MIN_KEY      = 3'd1,
    REG_DOMINANCE    = 3'd2,
    REG_SHADOW       = 3'd3
  } cfg_reg_t;

  localparam logic             ResetKeyBlue  = 1'b0;
  localparam logic [PixW-1:0]  ResetMinKey   = 8'd100;
  localparam logic [DomW-1:0]  ResetDominance = 16'd26214;
  localparam logic [ShadW-1:0] ResetShadow   = 12'd256;

  // Exact floor(x / 255) for x up to 65279.
  function automatic logic [PixW-1:0] div255(input logic [BlendW-1:0] x);
    logic [BlendW:0] t;
    t = {1'b0, x} + {9'd0, x[BlendW-1:PixW]} + {{BlendW{1'b0}}, 1'b1};
    return t[BlendW-1:PixW];
  endfunction

endpackage

// ===== hdl/chroma_key_composite.sv =====
`timescale 1ns / 1ps

// Accepted words move through the stage registers in order. Throughput:
// one pixel per cycle while out_stall is low; a stalled output backs up
// stage by stage and empty stages still fill, so in_stall rises only
// when all four are full. Reset (rst, synchronous, active high) empties
// the pipeline and loads the key registers with their default values.
module chroma_key_composite import ckc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IdxW-1:0]      cfg_index,
  input  logic [CfgW-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PixW-1:0]      fg_red,
  input  logic [PixW-1:0]      fg_green,
  input  logic [PixW-1:0]      fg_blue,
  input  logic [PixW-1:0]      bg_red,
  input  logic [PixW-1:0]      bg_green,
  input  logic [PixW-1:0]      bg_blue,
  input  logic [PixW-1:0]      mask_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PixW-1:0]      out_red,
  output logic [PixW-1:0]      out_green,
  output logic [PixW-1:0]      out_blue,
  output logic                 keyed
);

  // Config registers; the user must write them only with the pipeline idle.
  logic             key_blue;
  logic [PixW-1:0]  min_key_level;
  logic [DomW-1:0]  dominance_threshold;
  logic [ShadW-1:0] shadow_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_blue            <= ResetKeyBlue;
      min_key_level       <= ResetMinKey;
      dominance_threshold <= ResetDominance;
      shadow_factor       <= ResetShadow;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_BLUE:  key_blue            <= cfg_data[0];
        REG_MIN_KEY:   min_key_level       <= cfg_data[PixW-1:0];
        REG_DOMINANCE: dominance_threshold <= cfg_data[DomW-1:0];
        REG_SHADOW:    shadow_factor       <= cfg_data[ShadW-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Handshake: each stage advances when it is empty or the next one advances.
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready = !out_valid || !out_stall;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= in_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) s3_valid  <= s2_valid;
      if (s4_ready) out_valid <= s3_valid;
    end
  end

  // Stage 1: pick the key channel and its two rivals, form the channel sum
  // and the minimum-level test.
  logic [PixW-1:0] s1_k, s1_a, s1_b, s1_m;
  logic [SumW-1:0] s1_sum;
  logic            s1_above_min;
  logic [PixW-1:0] s1_fg [3];
  logic [PixW-1:0] s1_bg [3];
  logic [PixW-1:0] key_chan, rival_chan;

  assign key_chan   = key_blue ? fg_blue  : fg_green;
  assign rival_chan = key_blue ? fg_green : fg_blue;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_k         <= key_chan;
      s1_a         <= fg_red;
      s1_b         <= rival_chan;
      s1_m         <= mask_level;
      s1_sum       <= {2'b00, fg_red} + {2'b00, fg_green} + {2'b00, fg_blue};
      s1_above_min <= key_chan > min_key_level;
      s1_fg[0]     <= fg_red;
      s1_fg[1]     <= fg_green;
      s1_fg[2]     <= fg_blue;
      s1_bg[0]     <= bg_red;
      s1_bg[1]     <= bg_green;
      s1_bg[2]     <= bg_blue;
    end
  end

  // Stage 2: every multiply, side by side.
  logic [PixW-1:0]     s2_k;
  logic                s2_above_min;
  logic [ShProdW-1:0]  s2_shadow_a, s2_shadow_b;
  logic [DomProdW-1:0] s2_dom;
  logic [BlendW-1:0]   s2_wfg [3];
  logic [BlendW-1:0]   s2_wbg [3];
  logic [PixW-1:0]     s2_bg [3];
  logic [PixW-1:0]     inv_m;

  assign inv_m = PixMax - s1_m;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_k         <= s1_k;
      s2_above_min <= s1_above_min;
      s2_shadow_a  <= s1_a * shadow_factor;
      s2_shadow_b  <= s1_b * shadow_factor;
      s2_dom       <= dominance_threshold * s1_sum;
      for (int c = 0; c < 3; c++) begin
        s2_wfg[c] <= s1_m * s1_fg[c];
        s2_wbg[c] <= inv_m * s1_bg[c];
        s2_bg[c]  <= s1_bg[c];
      end
    end
  end

  // Stage 3: the cross-multiplied key compares and the blend sums.
  logic              s3_keyed;
  logic [BlendW-1:0] s3_blend [3];
  logic [PixW-1:0]   s3_bg [3];
  logic [ShProdW-1:0]  k_shadow;
  logic [DomProdW-1:0] k_dom;

  assign k_shadow = {{(ShProdW-BlendW){1'b0}}, s2_k, {PixW{1'b0}}};
  assign k_dom    = {{(DomProdW-PixW-DomW){1'b0}}, s2_k, {DomW{1'b0}}};

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_keyed <= s2_above_min && (k_shadow > s2_shadow_a) &&
                  (k_shadow > s2_shadow_b) && (k_dom > s2_dom);
      for (int c = 0; c < 3; c++) begin
        s3_blend[c] <= s2_wfg[c] + s2_wbg[c];
        s3_bg[c]    <= s2_bg[c];
      end
    end
  end

  // Stage 4: divide by 255 and pick background for keyed pixels; this is
  // the output register that holds a word while out_stall is high.
  always_ff @(posedge clk) begin
    if (s4_ready) begin
      keyed     <= s3_keyed;
      out_red   <= s3_keyed ? s3_bg[0] : div255(s3_blend[0]);
      out_green <= s3_keyed ? s3_bg[1] : div255(s3_blend[1]);
      out_blue  <= s3_keyed ? s3_bg[2] : div255(s3_blend[2]);
    end
  end

  // An accepted word always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted word lost at stage 1");

  // The input stalls only when every stage holds a word.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s2_valid && s3_valid && out_valid)
    else $error("input stalled with a bubble in the pipeline");

  // A word in stage 3 that may advance reaches the output register.
  a_s3_advance: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s4_ready |=> out_valid)
    else $error("stage 3 word dropped");

endmodule

// ===== verif/tb_chroma_key_composite.sv =====
`timescale 1ns / 1ps

module tb_chroma_key_composite;
  import ckc_pkg::*;

  localparam int ClkPeriod      = 10;
  localparam int ResetCycles    = 9;
  localparam int LatencyCycles  = 4;
  localparam int PhaseItems     = 130;
  localparam int PressureCycles = 120;
  localparam int QuietLimit     = 2000;
  localparam int MaxPrinted     = 40;

  typedef struct packed {
    logic [PixW-1:0] fg_r;
    logic [PixW-1:0] fg_g;
    logic [PixW-1:0] fg_b;
    logic [PixW-1:0] bg_r;
    logic [PixW-1:0] bg_g;
    logic [PixW-1:0] bg_b;
    logic [PixW-1:0] mask;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
    logic            keyed;
  } composite_t;

  // Clock, reset and every block input start at known values.
  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_write = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [PixW-1:0] fg_red = '0;
  logic [PixW-1:0] fg_green = '0;
  logic [PixW-1:0] fg_blue = '0;
  logic [PixW-1:0] bg_red = '0;
  logic [PixW-1:0] bg_green = '0;
  logic [PixW-1:0] bg_blue = '0;
  logic [PixW-1:0] mask_level = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [PixW-1:0] out_red;
  logic [PixW-1:0] out_green;
  logic [PixW-1:0] out_blue;
  logic            keyed;

  // Local copy of the key registers, tracked as they are written.
  logic             key_blue_q = ResetKeyBlue;
  logic [PixW-1:0]  min_key_q  = ResetMinKey;
  logic [DomW-1:0]  dom_q      = ResetDominance;
  logic [ShadW-1:0] shadow_q   = ResetShadow;

  pixel_t     pixels_to_send[$];
  composite_t composites_due[$];

  // Rates and hold-off requests, set per phase by the sequence below.
  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 31;
  int unsigned holds_requested = 0;

  bit          in_fire = 1'b0;
  int unsigned pixels_in = 0;
  int unsigned words_out = 0;
  int unsigned keyed_words = 0;
  int unsigned in_held_cycles = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;

  chroma_key_composite u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .fg_red     (fg_red),
    .fg_green   (fg_green),
    .fg_blue    (fg_blue),
    .bg_red     (bg_red),
    .bg_green   (bg_green),
    .bg_blue    (bg_blue),
    .mask_level (mask_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .keyed      (keyed)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Mask-weighted blend of one channel, floored.
  function automatic logic [PixW-1:0] mix(input int unsigned f, input int unsigned bgv,
                                          input int unsigned m);
    int unsigned acc;
    acc = (m * f + (255 - m) * bgv) / 255;
    return acc[PixW-1:0];
  endfunction

  // Key test plus either background pass-through or the blend.
  function automatic composite_t composite_pixel(input pixel_t p);
    composite_t  c;
    int unsigned k, a, b, total;
    if (key_blue_q) begin
      k = p.fg_b;
      a = p.fg_r;
      b = p.fg_g;
    end else begin
      k = p.fg_g;
      a = p.fg_r;
      b = p.fg_b;
    end
    total = int'(p.fg_r) + int'(p.fg_g) + int'(p.fg_b);
    // A black pixel has total zero, so the share test fails and it is never keyed.
    c.keyed = (k > min_key_q) && (k * 256 > a * shadow_q) && (k * 256 > b * shadow_q)
              && (k * 65536 > dom_q * total);
    if (c.keyed) begin
      c.r = p.bg_r;
      c.g = p.bg_g;
      c.b = p.bg_b;
    end else begin
      c.r = mix(p.fg_r, p.bg_r, p.mask);
      c.g = mix(p.fg_g, p.bg_g, p.mask);
      c.b = mix(p.fg_b, p.bg_b, p.mask);
    end
    return c;
  endfunction

  function automatic logic [PixW-1:0] to_pix(input int v);
    if (v < 0) return '0;
    if (v > 255) return PixMax;
    return v[PixW-1:0];
  endfunction

  // Bias toward pixels that pass the key test under the current settings,
  // and toward the edges of each compare; the rest is plain noise.
  function automatic pixel_t random_pixel();
    pixel_t      p;
    logic [63:0] raw;
    int          k, a, b, lim, style;
    raw = {$urandom, $urandom};
    p = raw[$bits(pixel_t)-1:0];
    style = $urandom_range(99);
    if (style < 65) begin
      if (style < 45) begin
        // Strong key channel, other channels under the shadow limit.
        k = $urandom_range(255, (min_key_q < PixMax) ? int'(min_key_q) + 1 : 255);
        lim = (shadow_q != 0) ? (k * 256 - 1) / int'(shadow_q) : 255;
        a = $urandom_range(to_pix(lim));
        b = $urandom_range(to_pix(lim));
      end else begin
        // Straddle the level and shadow compares.
        k = to_pix(int'(min_key_q) + int'($urandom_range(2)) - 1);
        lim = (shadow_q != 0) ? k * 256 / int'(shadow_q) : int'($urandom_range(255));
        a = to_pix(lim + int'($urandom_range(2)) - 1);
        b = $urandom_range(to_pix(a));
      end
      if (key_blue_q) begin
        p.fg_b = to_pix(k);
        p.fg_r = to_pix(a);
        p.fg_g = to_pix(b);
      end else begin
        p.fg_g = to_pix(k);
        p.fg_r = to_pix(a);
        p.fg_b = to_pix(b);
      end
    end
    style = $urandom_range(99);
    if (style < 10) p.mask = '0;
    else if (style < 20) p.mask = PixMax;
    return p;
  endfunction

  task automatic queue_pixel(input int fr, fgc, fb, br, bgc, bb, m);
    pixel_t p;
    p.fg_r = fr[PixW-1:0];
    p.fg_g = fgc[PixW-1:0];
    p.fg_b = fb[PixW-1:0];
    p.bg_r = br[PixW-1:0];
    p.bg_g = bgc[PixW-1:0];
    p.bg_b = bb[PixW-1:0];
    p.mask = m[PixW-1:0];
    pixels_to_send.push_back(p);
  endtask

  // Write one register; only called while the pipeline is empty.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_KEY_BLUE:  key_blue_q = val[0];
      REG_MIN_KEY:   min_key_q  = val[PixW-1:0];
      REG_DOMINANCE: dom_q      = val[DomW-1:0];
      REG_SHADOW:    shadow_q   = val[ShadW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_settings(input logic [CfgW-1:0] kb, mk, dom, shd);
    write_reg(REG_KEY_BLUE, kb);
    write_reg(REG_MIN_KEY, mk);
    write_reg(REG_DOMINANCE, dom);
    write_reg(REG_SHADOW, shd);
  endtask

  task automatic send_random(input int count);
    repeat (count) pixels_to_send.push_back(random_pixel());
  endtask

  // Wait until every queued pixel went in and its word came back out,
  // then let the pipeline settle before touching the registers.
  task automatic drain();
    while (pixels_to_send.size() != 0 || in_valid || composites_due.size() != 0)
      @(negedge clk);
    repeat (LatencyCycles + 2) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MaxPrinted)
      $display("%0t ns: %s mismatch on output word %0d: got %0d, expected %0d",
               $time, what, words_out, got, want);
    mismatches++;
  endtask

  // Sender: advance to the next pixel once the current word is taken, and
  // idle at random; hold the payload steady while it is stalled.
  always @(negedge clk) begin : sender
    pixel_t nxt;
    if (!in_valid || in_fire) begin
      if (!rst && pixels_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pixels_to_send.pop_front();
        fg_red     <= nxt.fg_r;
        fg_green   <= nxt.fg_g;
        fg_blue    <= nxt.fg_b;
        bg_red     <= nxt.bg_r;
        bg_green   <= nxt.bg_g;
        bg_blue    <= nxt.bg_b;
        mask_level <= nxt.mask;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and hold off solidly when a phase asks for it
  // so that the pipeline fills and pushes back on the sender.
  always @(negedge clk) begin : receiver
    int unsigned holds_served;
    int unsigned hold_left;
    if (holds_served != holds_requested) begin
      holds_served = holds_requested;
      hold_left = PressureCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: predict each accepted pixel, check each accepted output word
  // against the oldest prediction, field by field.
  always @(posedge clk) begin : monitor
    pixel_t     seen;
    composite_t want;
    in_fire <= in_valid && !in_stall;
    if (in_valid && in_stall) in_held_cycles++;
    if (in_valid && !in_stall) begin
      seen = {fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue, mask_level};
      composites_due.push_back(composite_pixel(seen));
      pixels_in++;
    end
    if (out_valid && !out_stall) begin
      if (composites_due.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = composites_due.pop_front();
        if (out_red !== want.r) report_mismatch("out_red", out_red, want.r);
        if (out_green !== want.g) report_mismatch("out_green", out_green, want.g);
        if (out_blue !== want.b) report_mismatch("out_blue", out_blue, want.b);
        if (keyed !== want.keyed) report_mismatch("keyed", keyed, want.keyed);
        if (want.keyed) keyed_words++;
      end
      words_out++;
    end
  end

  // Watchdog: give up when no word moves on either side for too long.
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QuietLimit) begin
        $display("Timeout: no word moved for %0d cycles", QuietLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : sequence_top
    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;

    // Directed pixels at the reset settings: key on green, level 100,
    // share about 0.4, shadow factor 1.0.
    queue_pixel(0, 0, 0, 200, 100, 50, 255);        // black foreground, never keyed
    queue_pixel(0, 255, 0, 10, 20, 30, 0);          // pure green, keyed
    queue_pixel(0, 255, 0, 10, 20, 30, 255);        // keyed ignores the mask
    queue_pixel(255, 255, 255, 0, 0, 0, 255);       // white, full mask gives foreground
    queue_pixel(255, 255, 255, 0, 0, 0, 0);         // zero mask gives background
    queue_pixel(255, 0, 0, 255, 255, 255, 128);
    queue_pixel(0, 100, 0, 9, 9, 9, 200);           // level tie, not keyed
    queue_pixel(0, 101, 0, 9, 9, 9, 200);           // just above level
    queue_pixel(100, 101, 0, 40, 50, 60, 70);       // red just under the shadow limit
    queue_pixel(101, 101, 0, 40, 50, 60, 70);       // red ties the shadow limit
    queue_pixel(0, 101, 100, 40, 50, 60, 70);
    queue_pixel(0, 101, 101, 40, 50, 60, 70);       // blue ties the shadow limit
    queue_pixel(76, 101, 75, 1, 2, 3, 4);           // share just over the threshold
    queue_pixel(76, 101, 76, 1, 2, 3, 4);           // share just under it
    queue_pixel(200, 150, 100, 255, 0, 255, 1);
    queue_pixel(17, 230, 40, 0, 255, 0, 254);
    drain();

    // Same idea keyed on blue.
    write_reg(REG_KEY_BLUE, 16'd1);
    queue_pixel(0, 0, 255, 1, 2, 3, 77);
    queue_pixel(0, 255, 0, 1, 2, 3, 77);
    queue_pixel(0, 0, 0, 255, 255, 255, 0);
    drain();

    // Fixed settings: defaults, all-zero, all-max (oversized data), two mid points.
    load_settings(CfgW'(ResetKeyBlue), CfgW'(ResetMinKey), CfgW'(ResetDominance),
                  CfgW'(ResetShadow));
    send_random(PhaseItems);
    drain();
    load_settings('0, '0, '0, '0);
    send_random(PhaseItems);
    drain();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(PhaseItems);
    drain();
    load_settings(16'd1, 16'd50, 16'd21845, 16'd128);
    send_random(PhaseItems);
    drain();
    load_settings(16'd0, 16'd200, 16'd40000, 16'd300);
    send_random(PhaseItems);
    drain();

    // Random settings with full-width data; poke the unused indexes too.
    for (int ph = 0; ph < 5; ph++) begin
      load_settings(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
      for (int i = int'(REG_SHADOW) + 1; i < (1 << IdxW); i++)
        write_reg(i[IdxW-1:0], CfgW'($urandom));
      if (ph == 1) begin
        // Back-pressure: sender keeps offering while the receiver holds off.
        tx_idle_pct = 0;
        holds_requested++;
      end else if (ph == 2) begin
        // Steady stream with no idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random(PhaseItems);
      drain();
      tx_idle_pct = 31;
      rx_idle_pct = 31;
    end

    if (composites_due.size() != 0)
      report_mismatch("missing words", 0, composites_due.size());

    $display("Run covered %0d pixels (%0d keyed, %0d blended) across %0d register writes,",
             pixels_in, keyed_words, words_out - keyed_words, reg_writes);
    $display("with the input held off for %0d cycles; %0d mismatches.",
             in_held_cycles, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
